// ===== rtl/sm3_pkg.sv =====
// Shared types, constants and helper functions for the SM3 hash engine.
`timescale 1ns / 1ps
package sm3_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_LOAD,
    ST_ROUND,
    ST_UPD,
    ST_ORD,
    ST_OWR
  } sm3_state_t;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic       ld_win;   // shift a block word into the schedule window
    logic       ld_wv;    // shift a chaining word into the working variables
    logic       rnd;      // run one compression round
    logic       upd;      // shift the working variables down during write-back
    logic [5:0] rnd_idx;  // round number
  } sm3_rnd_ctl_t;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlkWrds = 16;
  localparam int unsigned CvWrds  = 8;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    rotl32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    p0 = x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    p1 = x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

  // Round constant rotated left by the round number modulo 32
  function automatic logic [31:0] t_rot(input logic [5:0] j);
    logic [31:0] t;
    logic [4:0]  n;
    t = (j < 6'd16) ? 32'h79CC4519 : 32'h7A879D8A;
    n = j[4:0];
    if (n == 5'd0) begin
      t_rot = t;
    end else begin
      t_rot = (t << n) | (t >> (6'd32 - {1'b0, n}));
    end
  endfunction

  // Standard initial vector
  function automatic logic [31:0] sm3_iv(input logic [2:0] idx);
    case (idx)
      3'd0:    sm3_iv = 32'h7380166F;
      3'd1:    sm3_iv = 32'h4914B2B9;
      3'd2:    sm3_iv = 32'h172442D7;
      3'd3:    sm3_iv = 32'hDA8A0600;
      3'd4:    sm3_iv = 32'hA96F30BC;
      3'd5:    sm3_iv = 32'h163138AA;
      3'd6:    sm3_iv = 32'hE38DEE4D;
      default: sm3_iv = 32'hB0FB0E4E;
    endcase
  endfunction

endpackage

// ===== rtl/sm3_blk_buf.sv =====
// Message block buffer: 16 x 32 synchronous memory, one write and one read port.
`timescale 1ns / 1ps
module sm3_blk_buf
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [WordW-1:0] mem [BlkWrds];
  logic [WordW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sm3_cv_store.sv =====
// Chaining value store: 8 x 32 memory with per-entry valid bits; invalid entries read as the IV.
`timescale 1ns / 1ps
module sm3_cv_store
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        rd_en,
  input  logic [2:0]  rd_addr,
  input  logic        wr_en,
  input  logic [2:0]  wr_addr,
  input  logic [31:0] wr_data,
  output logic [31:0] rd_val
);

  logic [WordW-1:0]  mem [CvWrds];
  logic [CvWrds-1:0] vld_r;
  logic [WordW-1:0]  q_r;
  logic              q_vld_r;
  logic [2:0]        q_addr_r;

  // Valid bits: cleared on reset and at the end of each message
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, with the valid flag and address kept for the IV fallback
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r      <= mem[rd_addr];
      q_vld_r  <= vld_r[rd_addr];
      q_addr_r <= rd_addr;
    end
  end

  assign rd_val = q_vld_r ? q_r : sm3_iv(q_addr_r);

endmodule

// ===== rtl/sm3_round.sv =====
// Compression datapath: 16-word schedule window, working variables and the round function.
`timescale 1ns / 1ps
module sm3_round
  import sm3_pkg::*;
(
  input  logic         clk,
  input  sm3_rnd_ctl_t ctl,
  input  logic [31:0]  blk_word,
  input  logic [31:0]  cv_word,
  output logic [31:0]  wv_head
);

  logic [WordW-1:0] win_r [BlkWrds];
  logic [WordW-1:0] wv_r  [CvWrds];
  logic [WordW-1:0] w_new;
  logic [WordW-1:0] a12, ss1, ss2, ff, gg, tt1, tt2;

  // Message expansion: next schedule word from the window taps
  assign w_new = p1(win_r[0] ^ win_r[7] ^ rotl32(win_r[13], 15))
               ^ rotl32(win_r[3], 7) ^ win_r[10];

  // Round function
  always_comb begin
    a12 = rotl32(wv_r[0], 12);
    ss1 = rotl32(a12 + wv_r[4] + t_rot(ctl.rnd_idx), 7);
    ss2 = ss1 ^ a12;
    if (ctl.rnd_idx < 6'd16) begin
      ff = wv_r[0] ^ wv_r[1] ^ wv_r[2];
      gg = wv_r[4] ^ wv_r[5] ^ wv_r[6];
    end else begin
      ff = (wv_r[0] & wv_r[1]) | (wv_r[0] & wv_r[2]) | (wv_r[1] & wv_r[2]);
      gg = (wv_r[4] & wv_r[5]) | (~wv_r[4] & wv_r[6]);
    end
    tt1 = ff + wv_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2 = gg + wv_r[7] + ss1 + win_r[0];
  end

  // Schedule window
  always_ff @(posedge clk) begin
    if (ctl.ld_win || ctl.rnd) begin
      for (int i = 0; i < BlkWrds - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BlkWrds-1] <= ctl.ld_win ? blk_word : w_new;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (ctl.rnd) begin
      wv_r[0] <= tt1;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= rotl32(wv_r[1], 9);
      wv_r[3] <= wv_r[2];
      wv_r[4] <= p0(tt2);
      wv_r[5] <= wv_r[4];
      wv_r[6] <= rotl32(wv_r[5], 19);
      wv_r[7] <= wv_r[6];
    end else if (ctl.ld_wv || ctl.upd) begin
      for (int i = 0; i < CvWrds - 1; i++) begin
        wv_r[i] <= wv_r[i+1];
      end
      wv_r[CvWrds-1] <= cv_word;
    end
  end

  assign wv_head = wv_r[0];

endmodule

// ===== rtl/sm3_hash_engine.sv =====
// Top level of the SM3 hash engine: input packing, padding and compression sequencer.
// A word that does not complete a block is only packed and written; a block completion adds
//   a load of the schedule window and working variables, 64 rounds and a chaining update.
// Throughput: one message word per cycle while filling; input is held off while a block is compressed.
// A final word adds padding writes, one or two compressions, then a read and an output write per digest word.
// Reset (synchronous, rst_n low): chaining value back to the IV, length and fill cleared.
`timescale 1ns / 1ps
module sm3_hash_engine
  import sm3_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] byte_count, [39:35] zero
  input  logic        in_tlast,   // final_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast   // last_word
);

  sm3_state_t       state_r, state_nxt, ret_r, ret_nxt;
  logic [6:0]       seq_r, seq_nxt;
  logic [3:0]       wi_r, wi_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [1:0]       acc_cnt_r, acc_cnt_nxt;
  logic [LENGTH_BITS-1:0] bit_len_r, bit_len_nxt;

  logic [31:0]      out_data_r;
  logic [2:0]       out_idx_r;
  logic             out_last_r, out_vld_r;
  logic             out_load;

  logic             in_fire;
  logic [2:0]       cnt;
  logic [31:0]      dmask;
  logic [63:0]      comb;
  logic [2:0]       total;
  logic [63:0]      len64;

  logic             blk_wr_en;
  logic [31:0]      blk_wr_data;
  logic [3:0]       blk_rd_addr;
  logic [31:0]      blk_rd_data;
  logic             cv_rd_en, cv_wr_en, cv_clr;
  logic [2:0]       cv_rd_addr, cv_wr_addr;
  logic [31:0]      cv_wr_data, cv_val;
  logic [31:0]      wv_head;
  sm3_rnd_ctl_t     rctl;
  logic             slot_free;

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_vld_r || out_tready;
  assign len64     = 64'(bit_len_r);

  // Byte packing: merge the held partial word with the new valid bytes
  always_comb begin
    cnt = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];
    case (cnt)
      3'd0:    dmask = 32'h0000_0000;
      3'd1:    dmask = 32'hFF00_0000;
      3'd2:    dmask = 32'hFFFF_0000;
      3'd3:    dmask = 32'hFFFF_FF00;
      default: dmask = 32'hFFFF_FFFF;
    endcase
    comb  = {acc_r, 32'h0} | ({in_tdata[31:0] & dmask, 32'h0} >> {acc_cnt_r, 3'b000});
    total = {1'b0, acc_cnt_r} + cnt;
  end

  // Next state and counters
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    seq_nxt     = seq_r;
    wi_nxt      = wi_r;
    acc_nxt     = acc_r;
    acc_cnt_nxt = acc_cnt_r;
    bit_len_nxt = bit_len_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          bit_len_nxt = bit_len_r + LENGTH_BITS'({cnt, 3'b000});
          acc_cnt_nxt = total[1:0];
          acc_nxt     = total[2] ? comb[31:0] : comb[63:32];
          if (total[2]) begin
            wi_nxt = wi_r + 4'd1;
          end
          if (total[2] && wi_r == 4'd15) begin
            state_nxt = ST_LOAD;
            seq_nxt   = '0;
            ret_nxt   = in_tlast ? ST_PAD : ST_IDLE;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wi_nxt      = wi_r + 4'd1;
        acc_nxt     = '0;
        acc_cnt_nxt = '0;
        if (wi_r == 4'd15) begin
          state_nxt = ST_LOAD;
          seq_nxt   = '0;
          ret_nxt   = ST_ZERO;
        end else begin
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (wi_r == 4'd14) begin
          state_nxt = ST_LEN_HI;
        end else begin
          wi_nxt = wi_r + 4'd1;
          if (wi_r == 4'd15) begin
            state_nxt = ST_LOAD;
            seq_nxt   = '0;
            ret_nxt   = ST_ZERO;
          end
        end
      end
      ST_LEN_HI: begin
        wi_nxt    = wi_r + 4'd1;
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        wi_nxt    = wi_r + 4'd1;
        state_nxt = ST_LOAD;
        seq_nxt   = '0;
        ret_nxt   = ST_ORD;
      end
      ST_LOAD: begin
        if (seq_r == 7'd16) begin
          state_nxt = ST_ROUND;
          seq_nxt   = '0;
        end else begin
          seq_nxt = seq_r + 7'd1;
        end
      end
      ST_ROUND: begin
        if (seq_r == 7'd63) begin
          state_nxt = ST_UPD;
          seq_nxt   = '0;
        end else begin
          seq_nxt = seq_r + 7'd1;
        end
      end
      ST_UPD: begin
        if (seq_r == 7'd8) begin
          state_nxt = ret_r;
          seq_nxt   = '0;
        end else begin
          seq_nxt = seq_r + 7'd1;
        end
      end
      ST_ORD: begin
        state_nxt = ST_OWR;
      end
      ST_OWR: begin
        if (slot_free) begin
          if (seq_r[2:0] == 3'd7) begin
            state_nxt   = ST_IDLE;
            seq_nxt     = '0;
            bit_len_nxt = '0;
          end else begin
            state_nxt = ST_ORD;
            seq_nxt   = seq_r + 7'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory strobes and datapath control
  always_comb begin
    in_tready   = 1'b0;
    blk_wr_en   = 1'b0;
    blk_wr_data = '0;
    blk_rd_addr = seq_r[3:0];
    cv_rd_en    = 1'b0;
    cv_rd_addr  = seq_r[2:0];
    cv_wr_en    = 1'b0;
    cv_wr_addr  = 3'(seq_r - 7'd1);
    cv_wr_data  = cv_val ^ wv_head;
    cv_clr      = 1'b0;
    out_load    = 1'b0;
    rctl        = '{ld_win: 1'b0, ld_wv: 1'b0, rnd: 1'b0, upd: 1'b0, rnd_idx: seq_r[5:0]};
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        blk_wr_en   = in_fire && total[2];
        blk_wr_data = comb[63:32];
      end
      ST_PAD: begin
        blk_wr_en   = 1'b1;
        blk_wr_data = acc_r | (32'h0000_0080 << (5'd24 - {acc_cnt_r, 3'b000}));
      end
      ST_ZERO: begin
        blk_wr_en = (wi_r != 4'd14);
      end
      ST_LEN_HI: begin
        blk_wr_en   = 1'b1;
        blk_wr_data = len64[63:32];
      end
      ST_LEN_LO: begin
        blk_wr_en   = 1'b1;
        blk_wr_data = len64[31:0];
      end
      ST_LOAD: begin
        cv_rd_en    = (seq_r < 7'd8);
        rctl.ld_win = (seq_r != 7'd0);
        rctl.ld_wv  = (seq_r != 7'd0) && (seq_r <= 7'd8);
      end
      ST_ROUND: begin
        rctl.rnd = 1'b1;
      end
      ST_UPD: begin
        cv_rd_en = (seq_r < 7'd8);
        cv_wr_en = (seq_r != 7'd0);
        rctl.upd = (seq_r != 7'd0);
      end
      ST_ORD: begin
        cv_rd_en = 1'b1;
      end
      ST_OWR: begin
        out_load = slot_free;
        cv_clr   = slot_free && (seq_r[2:0] == 3'd7);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ret_r     <= ST_IDLE;
      seq_r     <= '0;
      wi_r      <= '0;
      acc_r     <= '0;
      acc_cnt_r <= '0;
      bit_len_r <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      seq_r     <= seq_nxt;
      wi_r      <= wi_nxt;
      acc_r     <= acc_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      bit_len_r <= bit_len_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= cv_val;
      out_idx_r  <= seq_r[2:0];
      out_last_r <= (seq_r[2:0] == 3'd7);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_idx_r, out_data_r};
  assign out_tlast  = out_last_r;

  sm3_blk_buf u_blk_buf (
    .clk     (clk),
    .wr_en   (blk_wr_en),
    .wr_addr (wi_r),
    .wr_data (blk_wr_data),
    .rd_addr (blk_rd_addr),
    .rd_data (blk_rd_data)
  );

  sm3_cv_store u_cv_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cv_clr),
    .rd_en   (cv_rd_en),
    .rd_addr (cv_rd_addr),
    .wr_en   (cv_wr_en),
    .wr_addr (cv_wr_addr),
    .wr_data (cv_wr_data),
    .rd_val  (cv_val)
  );

  sm3_round u_round (
    .clk      (clk),
    .ctl      (rctl),
    .blk_word (blk_rd_data),
    .cv_word  (cv_val),
    .wv_head  (wv_head)
  );

`ifndef SYNTHESIS
  // Rounds advance one per cycle
  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && seq_r != 7'd63) |=> (seq_r == $past(seq_r) + 7'd1))
    else $error("round counter skipped");

  // Block buffer is not written while a compression is running
  a_no_blk_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD || state_r == ST_ROUND || state_r == ST_UPD) |-> !blk_wr_en)
    else $error("block buffer written during compression");

  // No input taken while a compression or digest is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input accepted while busy");

  // Loading the last digest word clears the chaining valids and returns to idle
  a_digest_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && seq_r[2:0] == 3'd7) |=> (state_r == ST_IDLE && out_tlast))
    else $error("digest did not close cleanly");
`endif

endmodule
